// ===== rtl/core/sha256_stream_hasher_core_assert.svh =====
// Assertion macros shared by the hasher RTL.
`ifndef SHA256_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_STREAM_HASHER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SHASH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SHASH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/shash_pkg.sv =====
// Types, constants and round functions of the SHA-256 stream hasher.
`default_nettype none
package shash_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} shash_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        last_word;
	} shash_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FINAL,
		ST_OUT
	} shash_state_t;

	// Commands from the sequencer to the compression datapath.
	typedef struct packed {
		logic       push;
		logic [7:0] dbyte;
		logic       start;
		logic       step;
		logic       finish;
		logic       init;
	} shash_ctrl_t;

	typedef struct packed {
		logic last_round;
	} shash_stat_t;

	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [5:0] LEN_SLOT  = 6'd56;
	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [7:0] PAD_ZERO  = 8'h00;
	localparam logic [2:0] WORD_LAST = 3'd7;
	localparam logic [5:0] ROUND_LAST = 6'd63;

	localparam logic [31:0] HASH_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] dbl;
		dbl = {x, x} >> n;
		return dbl[31:0];
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/shash_compress.sv =====
// Message window, message schedule, round datapath and hash state of the hasher.
`default_nettype none
module shash_compress
	import shash_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire shash_ctrl_t       ctrl,
	output shash_stat_t            stat,
	output logic [7:0][31:0]       hash_words
);

	logic [31:0]  hash_q [8];
	logic [31:0]  v_q [8];
	logic [511:0] win_q;
	logic [5:0]   rnd_q;

	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] t1, t2;

	// Word 0 of the window is the schedule word of the current round.
	assign w0  = win_q[511:480];
	assign w1  = win_q[479:448];
	assign w9  = win_q[223:192];
	assign w14 = win_q[63:32];
	assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

	assign t1 = v_q[7] + big_sigma1(v_q[4])
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ ROUND_K[rnd_q] + w0;
	assign t2 = big_sigma0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign stat.last_round = (rnd_q == ROUND_LAST);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			hash_words[i] = hash_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= HASH_INIT[i];
			end
			rnd_q <= '0;
		end else begin
			if (ctrl.init) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= HASH_INIT[i];
				end
			end else if (ctrl.finish) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + v_q[i];
				end
			end
			if (ctrl.start) begin
				rnd_q <= '0;
			end else if (ctrl.step) begin
				rnd_q <= rnd_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			win_q <= {win_q[503:0], ctrl.dbyte};
		end else if (ctrl.step) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (ctrl.start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= hash_q[i];
			end
		end else if (ctrl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sha256_stream_hasher_core.sv =====
// SHA-256 stream hasher: byte input channel, digest word output channel.
// The msg channel takes one beat per message byte (has_byte) and marks the
// last beat with end_of_message; an end beat without a byte closes an empty
// message or one whose last byte came earlier. A beat with neither flag does
// nothing. The dig channel returns the eight digest words of a message, word
// 0 first, with last_word set on word 7.
// Byte beats are taken only while idle. The 64th byte of a block starts the
// shared round unit: 64 rounds, one per cycle, then a fold of the result into
// the hash. An end beat feeds padding and length bytes through the same byte
// path, with one compression or two, and hands out the digest one word per
// cycle while the dig channel does not stall.
// msg_stall is high whenever the block is busy with rounds, the fold into the
// hash, padding or digest output. The dig beat sits in an output register, so
// the next message may start while the last digest word is still waiting.
// Reset loads the initial hash values and empties the block and length count.
`default_nettype none
module sha256_stream_hasher_core
	import shash_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       msg_valid,
	output logic            msg_stall,
	input  wire shash_in_t  msg,
	output logic            dig_valid,
	input  wire logic       dig_stall,
	output shash_out_t      dig
);

	`include "sha256_stream_hasher_core_assert.svh"

	shash_state_t state_q, state_nxt;
	shash_ctrl_t  ctrl;
	shash_stat_t  stat;

	logic [7:0][31:0] hash_words;

	logic [5:0]  fill_q;
	logic [63:0] total_q;
	logic        mark_q;
	logic        len_q;
	logic        endp_q;
	logic [2:0]  widx_q;
	logic        dig_valid_q;
	shash_out_t  dig_q;

	logic        msg_acc;
	logic        out_load;
	logic [63:0] len_bits;
	logic [63:0] len_shift;
	logic [7:0]  pad_byte;

	assign msg_acc  = msg_valid && !msg_stall;
	assign out_load = (state_q == ST_OUT) && (!dig_valid_q || !dig_stall);

	// Length bytes go out big-endian, one per slot from slot 56 to slot 63.
	assign len_bits  = {total_q[60:0], 3'b000};
	assign len_shift = len_bits << {fill_q[2:0], 3'b000};

	always_comb begin
		priority if (!mark_q) begin
			pad_byte = PAD_MARK;
		end else if (len_q || fill_q == LEN_SLOT) begin
			pad_byte = len_shift[63:56];
		end else begin
			pad_byte = PAD_ZERO;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (msg_acc) begin
					if (msg.has_byte && fill_q == FILL_LAST) begin
						state_nxt = ST_ROUND;
					end else if (msg.end_of_message) begin
						state_nxt = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (fill_q == FILL_LAST) begin
					state_nxt = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (stat.last_round) begin
					state_nxt = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (len_q) begin
					state_nxt = ST_OUT;
				end else if (endp_q) begin
					state_nxt = ST_PAD;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_load && widx_q == WORD_LAST) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		msg_stall   = (state_q != ST_IDLE);
		ctrl.push   = ((state_q == ST_IDLE) && msg_acc && msg.has_byte)
			|| (state_q == ST_PAD);
		ctrl.dbyte  = (state_q == ST_IDLE) ? msg.data_byte : pad_byte;
		ctrl.start  = ctrl.push && (fill_q == FILL_LAST);
		ctrl.step   = (state_q == ST_ROUND);
		ctrl.finish = (state_q == ST_FINAL);
		ctrl.init   = out_load && (widx_q == WORD_LAST);
	end

	shash_compress u_compress (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.hash_words (hash_words)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			total_q     <= '0;
			mark_q      <= 1'b0;
			len_q       <= 1'b0;
			endp_q      <= 1'b0;
			widx_q      <= '0;
			dig_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (ctrl.init) begin
				total_q <= '0;
				mark_q  <= 1'b0;
				len_q   <= 1'b0;
				endp_q  <= 1'b0;
			end else begin
				if ((state_q == ST_IDLE) && msg_acc && msg.has_byte) begin
					total_q <= total_q + 64'd1;
				end
				if ((state_q == ST_IDLE) && msg_acc && msg.end_of_message) begin
					endp_q <= 1'b1;
				end
				if (state_q == ST_PAD) begin
					mark_q <= 1'b1;
					if (mark_q && fill_q == LEN_SLOT) begin
						len_q <= 1'b1;
					end
				end
			end
			if (out_load) begin
				widx_q      <= widx_q + 3'd1;
				dig_valid_q <= 1'b1;
			end else if (!dig_stall) begin
				dig_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dig_q.digest_word <= hash_words[widx_q];
			dig_q.word_number <= widx_q;
			dig_q.last_word   <= (widx_q == WORD_LAST);
		end
	end

	assign dig_valid = dig_valid_q;
	assign dig       = dig_q;

	`SHASH_ASSERT_NOW(a_out_on_block_edge, state_q == ST_OUT, fill_q == '0,
		"digest output started inside a partly filled block")
	`SHASH_ASSERT_NOW(a_len_after_mark, len_q, mark_q,
		"length bytes started before the pad marker")
	`SHASH_ASSERT_NOW(a_idle_clean, state_q == ST_IDLE, !len_q && !mark_q,
		"padding flags left set after a message")
	`SHASH_ASSERT_NEXT(a_words_back_to_back,
		dig_valid && !dig_stall && !dig.last_word, dig_valid,
		"gap inside a digest")

endmodule
`default_nettype wire
